>>> sv/median_filter_3x3_assert.svh
// ----------------------------------------------------------------------------
// median_filter_3x3 assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_ASSERT_SVH
`define MEDIAN_FILTER_3X3_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MF3_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("median_filter_3x3 assertion failed");

// next-cycle implication
`define MF3_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("median_filter_3x3 assertion failed");

`else

`define MF3_ASSERT_IMP(label, clk, rst, ante, cons)
`define MF3_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// shared types, constants and sorting network helpers for the median filter
// ----------------------------------------------------------------------------
package mf3_pkg;

   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int DIM_LIMIT = 1024;
   localparam int QUEUE_DEPTH = 4;
   localparam int NUM_LAYERS = 9;
   localparam int MED_TAP = 4;

   typedef logic [7:0]  pix_type;
   typedef logic [9:0]  pos_type;
   typedef logic [10:0] dim_type;
   typedef logic [3:0]  tap_type;
   typedef logic [3:0]  emit_type;
   typedef pix_type [8:0] win_type;

   localparam dim_type RESET_WIDTH = 11'd320;
   localparam dim_type RESET_HEIGHT = 11'd240;
   localparam dim_type DIM_MIN = 11'd3;

   localparam logic CSR_IMAGE_WIDTH = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      pos_type wm1;
      pos_type hm1;
   } dims_type;

   typedef struct packed {
      pix_type  pixel;
      pos_type  row;
      pos_type  col;
      emit_type emit;
      logic     interior;
   } desc_type;

   function automatic dim_type clamp_dim(input dim_type v, input dim_type hi);
      dim_type r;
      if (v < DIM_MIN) begin
         r = DIM_MIN;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic win_type cmp_swap(input win_type w, input tap_type a, input tap_type b);
      win_type r;
      r = w;
      if (w[a] > w[b]) begin
         r[a] = w[b];
         r[b] = w[a];
      end
      return r;
   endfunction

   // one layer of the nine-input median network
   function automatic win_type sort_layer(input tap_type k, input win_type w);
      win_type r;
      unique case (k)
         4'd0, 4'd2: begin
            r = cmp_swap(cmp_swap(cmp_swap(w, 4'd1, 4'd2), 4'd4, 4'd5), 4'd7, 4'd8);
         end
         4'd1: begin
            r = cmp_swap(cmp_swap(cmp_swap(w, 4'd0, 4'd1), 4'd3, 4'd4), 4'd6, 4'd7);
         end
         4'd3: begin
            r = cmp_swap(cmp_swap(cmp_swap(w, 4'd0, 4'd3), 4'd5, 4'd8), 4'd4, 4'd7);
         end
         4'd4: begin
            r = cmp_swap(cmp_swap(cmp_swap(w, 4'd3, 4'd6), 4'd1, 4'd4), 4'd2, 4'd5);
         end
         4'd5: begin
            r = cmp_swap(w, 4'd4, 4'd7);
         end
         4'd6, 4'd8: begin
            r = cmp_swap(w, 4'd4, 4'd2);
         end
         4'd7: begin
            r = cmp_swap(w, 4'd6, 4'd4);
         end
         default: begin
            r = w;
         end
      endcase
      return r;
   endfunction

endpackage

>>> sv/median_filter_3x3.sv
// ----------------------------------------------------------------------------
// median_filter_3x3
// streaming 3x3 median filter for 8-bit grey frames in raster order
//
//   channel   direction  ports
//   req       in         req_valid, req_stall, req_pixel_in, req_frame_start
//   rsp       out        rsp_valid, rsp_stall, rsp_pixel_out, rsp_out_row,
//                        rsp_out_col, rsp_last_of_run
//   csr       in         csr_wr_en, csr_index, csr_wdata
//
// one pixel a cycle while req_stall is low; a pixel with k results holds the output register until all k are taken
// from accept to first result: read, window, 9 sort layers, output
// a four-entry queue lets the front keep accepting while the back is stalled
// synchronous reset; line stores are not cleared and hold no valid state
// ----------------------------------------------------------------------------
module median_filter_3x3 import mf3_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  pix_type req_pixel_in,
   input  logic    req_frame_start,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output pix_type rsp_pixel_out,
   output pos_type rsp_out_row,
   output pos_type rsp_out_col,
   output logic    rsp_last_of_run,
   input  logic    csr_wr_en,
   input  logic    csr_index,
   input  dim_type csr_wdata
);

   logic     push, q_full, q_empty, q_pop;
   desc_type push_desc, q_desc;
   dims_type dims;

   assign req_stall = q_full;

   mf3_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_pixel_in    (req_pixel_in),
      .req_frame_start (req_frame_start),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_full          (q_full),
      .push            (push),
      .push_desc       (push_desc),
      .dims            (dims)
   );

   mf3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_desc  (q_desc),
      .empty     (q_empty)
   );

   mf3_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_desc          (q_desc),
      .q_pop           (q_pop),
      .dims            (dims),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

>>> sv/mf3_queue.sv
// ----------------------------------------------------------------------------
// mf3_queue
// short fifo of classified pixel descriptors between front and back
// ----------------------------------------------------------------------------
`include "median_filter_3x3_assert.svh"

module mf3_queue import mf3_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   output logic     full,
   input  logic     pop,
   output desc_type pop_desc,
   output logic     empty
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   desc_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            wr, rd;

   assign full = (count_ff == CW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign wr = push && !full;
   assign rd = pop && !empty;
   assign pop_desc = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr && !rd) begin
         count_in = count_ff + 1'b1;
      end else if (rd && !wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   `MF3_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(QUEUE_DEPTH))
   `MF3_ASSERT_IMP(a_empty_ptrs, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff)

endmodule

>>> sv/mf3_front.sv
// ----------------------------------------------------------------------------
// mf3_front
// frame size registers, raster position tracking and result classification
// ----------------------------------------------------------------------------
module mf3_front import mf3_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  pix_type  req_pixel_in,
   input  logic     req_frame_start,
   input  logic     csr_wr_en,
   input  logic     csr_index,
   input  dim_type  csr_wdata,
   input  logic     q_full,
   output logic     push,
   output desc_type push_desc,
   output dims_type dims
);

   localparam dim_type WLIM = dim_type'((MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT);
   localparam dim_type HLIM = dim_type'(DIM_LIMIT);

   dim_type width_ff, width_in;
   dim_type height_ff, height_in;
   pos_type row_ff, row_in;
   pos_type col_ff, col_in;
   dim_type wdim, hdim;
   pos_type r, c;
   logic    row_end, last_row;

   always_comb begin
      wdim = clamp_dim(width_ff, WLIM);
      hdim = clamp_dim(height_ff, HLIM);
      dims.wm1 = pos_type'(wdim - 11'd1);
      dims.hm1 = pos_type'(hdim - 11'd1);
   end

   always_comb begin
      r = req_frame_start ? '0 : row_ff;
      c = req_frame_start ? '0 : col_ff;
      row_end = (c >= dims.wm1);
      last_row = (r >= dims.hm1);
      push = req_valid && !q_full;

      push_desc.pixel = req_pixel_in;
      push_desc.row = r;
      push_desc.col = c;
      push_desc.emit[0] = (r != '0) && (c != '0);
      push_desc.emit[1] = (r != '0) && row_end;
      push_desc.emit[2] = last_row && (c != '0);
      push_desc.emit[3] = last_row && row_end;
      push_desc.interior = (r >= 10'd2) && (r <= dims.hm1) && (c >= 10'd2) && (c <= dims.wm1);

      row_in = row_ff;
      col_in = col_ff;
      if (push) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : r + 1'b1;
         end else begin
            row_in = r;
            col_in = c + 1'b1;
         end
      end
   end

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default:          width_in = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

>>> sv/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median
// pipelined nine-input median network, one compare layer per stage
// ----------------------------------------------------------------------------
module mf3_median import mf3_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  win_type  in_win,
   input  desc_type in_desc,
   output logic     out_valid,
   output pix_type  out_med,
   output desc_type out_desc
);

   logic     valid_ff [NUM_LAYERS];
   win_type  win_ff   [NUM_LAYERS];
   desc_type desc_ff  [NUM_LAYERS];
   logic     valid_in [NUM_LAYERS];
   win_type  win_in   [NUM_LAYERS];
   desc_type desc_in  [NUM_LAYERS];

   for (genvar k = 0; k < NUM_LAYERS; k++) begin : g_layer
      if (k == 0) begin : g_first
         assign valid_in[k] = in_valid;
         assign win_in[k] = in_win;
         assign desc_in[k] = in_desc;
      end else begin : g_rest
         assign valid_in[k] = valid_ff[k-1];
         assign win_in[k] = win_ff[k-1];
         assign desc_in[k] = desc_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            win_ff[k] <= sort_layer(tap_type'(k), win_in[k]);
            desc_ff[k] <= desc_in[k];
         end
      end
   end

   assign out_valid = valid_ff[NUM_LAYERS-1];
   assign out_med = win_ff[NUM_LAYERS-1][MED_TAP];
   assign out_desc = desc_ff[NUM_LAYERS-1];

endmodule

>>> sv/mf3_back.sv
// ----------------------------------------------------------------------------
// mf3_back
// line stores, 3x3 window, median pipeline and result serializer
// ----------------------------------------------------------------------------
`include "median_filter_3x3_assert.svh"

module mf3_back import mf3_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  desc_type q_desc,
   output logic     q_pop,
   input  dims_type dims,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output pix_type  rsp_pixel_out,
   output pos_type  rsp_out_row,
   output pos_type  rsp_out_col,
   output logic     rsp_last_of_run
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   pix_type older_mem [MAX_WIDTH];
   pix_type newer_mem [MAX_WIDTH];

   logic          advance;
   logic [AW-1:0] rd_addr;
   logic          rd_inr;

   logic          a_valid_ff;
   desc_type      a_desc_ff;
   logic [AW-1:0] a_addr_ff;
   logic          a_inr_ff;
   pix_type       rd_older_ff, rd_newer_ff;
   logic          fwd_ff;
   pix_type       fwd_top_ff, fwd_mid_ff;
   pix_type       top_a, mid_a;

   win_type       win_ff, win_in;
   logic          w_valid_ff;
   desc_type      w_desc_ff;

   logic          med_valid;
   pix_type       med_out;
   desc_type      med_desc;

   emit_type      hold_emit_ff, hold_emit_in;
   pix_type       hold_pix_ff;
   pos_type       hold_row_ff, hold_col_ff;
   emit_type      rest;
   pos_type       rm1, cm1;

   // read stage with bypass of the write from the item just ahead
   assign rd_addr = AW'(q_desc.col);
   assign rd_inr = int'(q_desc.col) < MAX_WIDTH;
   assign q_pop = advance && !q_empty;

   always_comb begin
      if (!a_inr_ff) begin
         top_a = '0;
         mid_a = '0;
      end else if (fwd_ff) begin
         top_a = fwd_top_ff;
         mid_a = fwd_mid_ff;
      end else begin
         top_a = rd_older_ff;
         mid_a = rd_newer_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (q_pop) begin
            rd_older_ff <= older_mem[rd_addr];
            rd_newer_ff <= newer_mem[rd_addr];
         end
         if (a_valid_ff && a_inr_ff) begin
            older_mem[a_addr_ff] <= mid_a;
            newer_mem[a_addr_ff] <= a_desc_ff.pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         fwd_ff <= 1'b0;
         w_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= q_pop;
         fwd_ff <= q_pop && rd_inr && a_valid_ff && a_inr_ff && (rd_addr == a_addr_ff);
         w_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_desc_ff <= q_desc;
         a_addr_ff <= rd_addr;
         a_inr_ff <= rd_inr;
         fwd_top_ff <= mid_a;
         fwd_mid_ff <= a_desc_ff.pixel;
         w_desc_ff <= a_desc_ff;
      end
   end

   // window shifts one column per item
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         win_in[i] = win_ff[i+3];
      end
      win_in[6] = top_a;
      win_in[7] = mid_a;
      win_in[8] = a_desc_ff.pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (advance && a_valid_ff) begin
         win_ff <= win_in;
      end
   end

   mf3_median u_median (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (w_valid_ff),
      .in_win    (win_ff),
      .in_desc   (w_desc_ff),
      .out_valid (med_valid),
      .out_med   (med_out),
      .out_desc  (med_desc)
   );

   // result serializer, lowest pending kind first
   assign rest = hold_emit_ff & (hold_emit_ff - 4'd1);
   assign rsp_valid = (hold_emit_ff != '0);
   assign advance = !rsp_valid || (!rsp_stall && (rest == '0));
   assign rm1 = hold_row_ff - 1'b1;
   assign cm1 = hold_col_ff - 1'b1;

   always_comb begin
      hold_emit_in = hold_emit_ff;
      if (advance) begin
         hold_emit_in = med_valid ? med_desc.emit : '0;
      end else if (!rsp_stall) begin
         hold_emit_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_emit_ff <= '0;
      end else begin
         hold_emit_ff <= hold_emit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hold_pix_ff <= med_desc.interior ? med_out : '0;
         hold_row_ff <= med_desc.row;
         hold_col_ff <= med_desc.col;
      end
   end

   always_comb begin
      if (hold_emit_ff[0]) begin
         rsp_pixel_out = hold_pix_ff;
         rsp_out_row = rm1;
         rsp_out_col = cm1;
      end else if (hold_emit_ff[1]) begin
         rsp_pixel_out = '0;
         rsp_out_row = rm1;
         rsp_out_col = dims.wm1;
      end else if (hold_emit_ff[2]) begin
         rsp_pixel_out = '0;
         rsp_out_row = hold_row_ff;
         rsp_out_col = cm1;
      end else begin
         rsp_pixel_out = '0;
         rsp_out_row = hold_row_ff;
         rsp_out_col = dims.wm1;
      end
      rsp_last_of_run = (rest == '0);
   end

   `MF3_ASSERT_NXT(a_load_shows, clock, reset, advance && med_valid && (med_desc.emit != '0), rsp_valid)
   `MF3_ASSERT_IMP(a_last_single, clock, reset, rsp_valid && rsp_last_of_run, $onehot(hold_emit_ff))
   `MF3_ASSERT_IMP(a_fwd_valid, clock, reset, fwd_ff, a_valid_ff)

endmodule
